@@ design/bst_pkg.sv @@
// package for the byte stream tokenizer
// result types, event, kind and error codes, lexer states and result builders
package bst_pkg;

  localparam int PosWidthDef   = 16;
  localparam int ValueWidthDef = 64;
  localparam int PosOut        = 16;
  localparam int ValueOut      = 64;
  localparam int MaxRes        = 3;
  localparam int DataBits      = 152;

  typedef enum logic [1:0] {
    EV_TEXT  = 2'd0,
    EV_TOKEN = 2'd1,
    EV_ERROR = 2'd2
  } event_t;

  localparam logic [3:0] K_END    = 4'd0;
  localparam logic [3:0] K_IDENT  = 4'd1;
  localparam logic [3:0] K_SHORT  = 4'd2;
  localparam logic [3:0] K_LONG   = 4'd3;
  localparam logic [3:0] K_TYPE   = 4'd4;
  localparam logic [3:0] K_STRING = 4'd5;
  localparam logic [3:0] K_REGEX  = 4'd6;
  localparam logic [3:0] K_INT    = 4'd7;
  localparam logic [3:0] K_DEC    = 4'd8;
  localparam logic [3:0] K_DOTS   = 4'd9;
  localparam logic [3:0] K_LSQ    = 4'd10;
  localparam logic [3:0] K_RSQ    = 4'd11;
  localparam logic [3:0] K_LCUR   = 4'd12;
  localparam logic [3:0] K_RCUR   = 4'd13;
  localparam logic [3:0] K_SEMI   = 4'd14;

  localparam logic [3:0] E_UNEXPECTED  = 4'd0;
  localparam logic [3:0] E_ILL_SHORT   = 4'd1;
  localparam logic [3:0] E_EMPTY_SHORT = 4'd2;
  localparam logic [3:0] E_ILL_LONG    = 4'd3;
  localparam logic [3:0] E_EMPTY_LONG  = 4'd4;
  localparam logic [3:0] E_ILL_TYPE    = 4'd5;
  localparam logic [3:0] E_EMPTY_TYPE  = 4'd6;
  localparam logic [3:0] E_ILL_STRING  = 4'd7;
  localparam logic [3:0] E_ILL_NEG     = 4'd8;
  localparam logic [3:0] E_EMPTY_NEG   = 4'd9;
  localparam logic [3:0] E_OPEN_COMM   = 4'd10;

  typedef enum logic [18:0] {
    S_START = 19'h00001,
    S_R     = 19'h00002,
    S_ID    = 19'h00004,
    S_DASH  = 19'h00008,
    S_DASH2 = 19'h00010,
    S_LONG  = 19'h00020,
    S_TYPE0 = 19'h00040,
    S_TYPE  = 19'h00080,
    S_STR   = 19'h00100,
    S_ESC   = 19'h00200,
    S_NUM0  = 19'h00400,
    S_NUM   = 19'h00800,
    S_DEC   = 19'h01000,
    S_DOT1  = 19'h02000,
    S_DOT2  = 19'h04000,
    S_COM0  = 19'h08000,
    S_LINE  = 19'h10000,
    S_BLOCK = 19'h20000,
    S_STAR  = 19'h40000
  } state_t;

  // packed from the lowest bit up: text, kind, error, value, overflow, positions
  typedef struct packed {
    logic [PosOut-1:0]   ec;
    logic [PosOut-1:0]   el;
    logic [PosOut-1:0]   sc;
    logic [PosOut-1:0]   sl;
    logic                ovf;
    logic [ValueOut-1:0] ival;
    logic [3:0]          err;
    logic [3:0]          kind;
    logic [7:0]          text;
  } res_data_t;

  typedef struct packed {
    event_t    ev;
    res_data_t data;
  } result_t;

  function automatic result_t mk_text(input logic [7:0] ch);
    result_t r;
    r = '0;
    r.ev = EV_TEXT;
    r.data.text = ch;
    return r;
  endfunction

  function automatic result_t mk_tok(input logic [3:0] kind, input logic [ValueOut-1:0] ival,
                                     input logic ovf, input logic [PosOut-1:0] sl,
                                     input logic [PosOut-1:0] sc, input logic [PosOut-1:0] el,
                                     input logic [PosOut-1:0] ec);
    result_t r;
    r = '0;
    r.ev = EV_TOKEN;
    r.data.kind = kind;
    r.data.ival = ival;
    r.data.ovf = ovf;
    r.data.sl = sl;
    r.data.sc = sc;
    r.data.el = el;
    r.data.ec = ec;
    return r;
  endfunction

  function automatic result_t mk_err(input logic [3:0] code, input logic [PosOut-1:0] l,
                                     input logic [PosOut-1:0] c);
    result_t r;
    r = '0;
    r.ev = EV_ERROR;
    r.data.err = code;
    r.data.sl = l;
    r.data.sc = c;
    r.data.el = l;
    r.data.ec = c;
    return r;
  endfunction

endpackage

@@ design/bst_lexer.sv @@
// lexer automaton: state registers and the combinational step for one byte
// depends on bst_pkg
module bst_lexer #(
  parameter int POS_WIDTH   = bst_pkg::PosWidthDef,
  parameter int VALUE_WIDTH = bst_pkg::ValueWidthDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          byte_in,
  input  logic                end_of_input,
  output bst_pkg::result_t    res [bst_pkg::MaxRes],
  output logic [1:0]          res_cnt
);
  import bst_pkg::*;

  localparam logic [POS_WIDTH-1:0] PMax = {POS_WIDTH{1'b1}};
  localparam logic [POS_WIDTH-1:0] POne = POS_WIDTH'(1);
  localparam int WW = VALUE_WIDTH + 4;
  localparam logic [WW-1:0] Half = WW'(1) << (VALUE_WIDTH - 1);

  typedef struct packed {
    state_t                 st;
    logic [3:0]             ck;
    logic [VALUE_WIDTH-1:0] acc;
    logic                   neg;
    logic                   ovf;
    logic [POS_WIDTH-1:0]   line;
    logic [POS_WIDTH-1:0]   col;
    logic [POS_WIDTH-1:0]   tline;
    logic [POS_WIDTH-1:0]   tcol;
  } lex_t;

  lex_t    lx;
  lex_t    lx_next;
  lex_t    n1;
  lex_t    n2;
  result_t a0, a1, b0, b1;
  logic [1:0] c1, c2;
  logic    g1, g2;

  function automatic logic [PosOut-1:0] p16(input logic [POS_WIDTH-1:0] p);
    return PosOut'(p);
  endfunction

  function automatic lex_t f_col(input lex_t s);
    lex_t t;
    t = s;
    if (t.col != PMax) t.col = t.col + POne;
    return t;
  endfunction

  function automatic lex_t f_nl(input lex_t s);
    lex_t t;
    t = s;
    if (t.line != PMax) t.line = t.line + POne;
    t.col = POne;
    return t;
  endfunction

  function automatic lex_t f_mark(input lex_t s);
    lex_t t;
    t = s;
    t.tline = s.line;
    t.tcol = s.col;
    t.acc = '0;
    t.neg = 1'b0;
    t.ovf = 1'b0;
    return t;
  endfunction

  function automatic lex_t f_fail(input lex_t s, input logic e, input logic [7:0] c);
    lex_t t;
    t = s;
    if (!e && c == 8'h0a) t = f_nl(s);
    else if (!e) t = f_col(s);
    t.st = S_START;
    return t;
  endfunction

  function automatic lex_t f_digit(input lex_t s, input logic [7:0] c);
    lex_t t;
    logic [WW-1:0] v;
    logic [WW-1:0] a10;
    logic [WW-1:0] m10;
    logic [VALUE_WIDTH-1:0] mag;
    t = s;
    v = WW'(c - 8'h30);
    a10 = (WW'(s.acc) << 3) + (WW'(s.acc) << 1);
    mag = -s.acc;
    m10 = (WW'(mag) << 3) + (WW'(mag) << 1);
    if (!s.ovf) begin
      if (s.neg) t.ovf = (m10 + v) > Half;
      else t.ovf = (a10 + v) > (Half - WW'(1));
    end
    if (s.neg) t.acc = VALUE_WIDTH'(a10 - v);
    else t.acc = VALUE_WIDTH'(a10 + v);
    return t;
  endfunction

  function automatic result_t f_tok(input lex_t s, input logic [3:0] k,
                                    input logic [POS_WIDTH-1:0] l2,
                                    input logic [POS_WIDTH-1:0] c2);
    logic [ValueOut-1:0] iv;
    logic                ov;
    iv = '0;
    ov = 1'b0;
    if (k == K_INT) begin
      iv = ValueOut'(signed'(s.acc));
      ov = s.ovf;
    end
    return mk_tok(k, iv, ov, p16(s.tline), p16(s.tcol), p16(l2), p16(c2));
  endfunction

  function automatic void do_pass(input lex_t s, input logic e, input logic [7:0] cin,
                                  output lex_t n, output result_t r0, output result_t r1,
                                  output logic [1:0] cnt, output logic again);
    logic [7:0] c;
    logic al, dg, an, idn, ws, prt;
    logic [POS_WIDTH-1:0] cp;
    logic [3:0] bk;
    c = e ? 8'h00 : cin;
    al = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    dg = c >= "0" && c <= "9";
    an = al || dg;
    idn = an || c == "_" || c == "-";
    ws = c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a;
    prt = c >= " " && c <= "~";
    cp = (s.col > POne) ? s.col - POne : POne;
    bk = (c == "[") ? K_LSQ : (c == "]") ? K_RSQ : (c == "{") ? K_LCUR :
         (c == "}") ? K_RCUR : K_SEMI;
    n = s;
    r0 = '0;
    r1 = '0;
    cnt = 2'd0;
    again = 1'b0;
    case (s.st)
      S_START: begin
        if (e) begin
          n.tline = s.line;
          n.tcol = s.col;
          r0 = f_tok(n, K_END, s.line, s.col);
          cnt = 2'd1;
        end else if (al) begin
          n = f_col(f_mark(s));
          n.ck = K_IDENT;
          r0 = mk_text(c);
          cnt = 2'd1;
          n.st = (c == "r") ? S_R : S_ID;
        end else if (c == "-") begin
          n = f_col(f_mark(s));
          n.st = S_DASH;
        end else if (c == "<") begin
          n = f_col(f_mark(s));
          n.ck = K_TYPE;
          n.st = S_TYPE0;
        end else if (c == "\"") begin
          n = f_col(f_mark(s));
          n.ck = K_STRING;
          n.st = S_STR;
        end else if (dg) begin
          n = f_col(f_digit(f_mark(s), c));
          r0 = mk_text(c);
          cnt = 2'd1;
          n.st = S_NUM;
        end else if (c == ".") begin
          n = f_col(f_mark(s));
          n.st = S_DOT1;
        end else if (c == "/") begin
          n = f_col(s);
          n.st = S_COM0;
        end else if (c == "[" || c == "]" || c == "{" || c == "}" || c == ";") begin
          n.tline = s.line;
          n.tcol = s.col;
          r0 = mk_text(c);
          r1 = f_tok(n, bk, s.line, s.col);
          cnt = 2'd2;
          n = f_col(n);
        end else if (c == 8'h0a) begin
          n = f_nl(s);
        end else if (ws) begin
          n = f_col(s);
        end else begin
          r0 = mk_err(E_UNEXPECTED, p16(s.line), p16(s.col));
          cnt = 2'd1;
          n = f_fail(s, e, c);
        end
      end
      S_R, S_ID, S_LONG, S_DEC: begin
        if (s.st == S_R && c == "\"") begin
          n = f_col(s);
          n.ck = K_REGEX;
          n.st = S_STR;
        end else if ((s.st == S_DEC) ? dg : idn) begin
          n = f_col(s);
          r0 = mk_text(c);
          cnt = 2'd1;
          if (s.st == S_R) n.st = S_ID;
        end else begin
          r0 = f_tok(s, (s.st == S_LONG) ? K_LONG : (s.st == S_DEC) ? K_DEC : K_IDENT,
                     s.line, cp);
          cnt = 2'd1;
          n.st = S_START;
          again = 1'b1;
        end
      end
      S_DASH: begin
        if (an || c == "?") begin
          r0 = mk_text(c);
          r1 = f_tok(s, K_SHORT, s.line, s.col);
          cnt = 2'd2;
          n = f_col(s);
          n.st = S_START;
        end else if (c == "-") begin
          n = f_col(s);
          n.st = S_DASH2;
        end else begin
          r0 = ws ? mk_err(E_EMPTY_SHORT, p16(s.line), p16(cp))
                  : mk_err(E_ILL_SHORT, p16(s.line), p16(s.col));
          cnt = 2'd1;
          n = f_fail(s, e, c);
        end
      end
      S_DASH2: begin
        if (an || c == "_") begin
          n = f_col(s);
          r0 = mk_text(c);
          cnt = 2'd1;
          n.st = S_LONG;
        end else if (c == "-") begin
          n = f_col(s);
          r0 = mk_text(c);
          cnt = 2'd1;
          n.neg = 1'b1;
          n.st = S_NUM0;
        end else begin
          r0 = ws ? mk_err(E_EMPTY_LONG, p16(s.line), p16(cp))
                  : mk_err(E_ILL_LONG, p16(s.line), p16(s.col));
          cnt = 2'd1;
          n = f_fail(s, e, c);
        end
      end
      S_TYPE0, S_TYPE: begin
        if (idn) begin
          n = f_col(s);
          r0 = mk_text(c);
          cnt = 2'd1;
          n.st = S_TYPE;
        end else if (c == ">" && s.st == S_TYPE) begin
          r0 = f_tok(s, K_TYPE, s.line, s.col);
          cnt = 2'd1;
          n = f_col(s);
          n.st = S_START;
        end else begin
          r0 = mk_err((c == ">") ? E_EMPTY_TYPE : E_ILL_TYPE, p16(s.line), p16(s.col));
          cnt = 2'd1;
          n = f_fail(s, e, c);
        end
      end
      S_STR: begin
        if (c == "\\") begin
          n = f_col(s);
          r0 = mk_text(c);
          cnt = 2'd1;
          n.st = S_ESC;
        end else if (c == "\"") begin
          r0 = f_tok(s, (s.ck == K_REGEX) ? K_REGEX : K_STRING, s.line, s.col);
          cnt = 2'd1;
          n = f_col(s);
          n.st = S_START;
        end else if (prt) begin
          n = f_col(s);
          r0 = mk_text(c);
          cnt = 2'd1;
        end else begin
          r0 = mk_err(E_ILL_STRING, p16(s.line), p16(s.col));
          cnt = 2'd1;
          n = f_fail(s, e, c);
        end
      end
      S_ESC: begin
        if (prt) begin
          n = f_col(s);
          r0 = mk_text(c);
          cnt = 2'd1;
          n.st = S_STR;
        end else begin
          r0 = mk_err(E_ILL_STRING, p16(s.line), p16(s.col));
          cnt = 2'd1;
          n = f_fail(s, e, c);
        end
      end
      S_NUM0, S_NUM: begin
        if (dg) begin
          n = f_col(f_digit(s, c));
          r0 = mk_text(c);
          cnt = 2'd1;
          n.st = S_NUM;
        end else if (s.st == S_NUM && c == ".") begin
          n = f_col(s);
          r0 = mk_text(c);
          cnt = 2'd1;
          n.st = S_DEC;
        end else if (s.st == S_NUM) begin
          r0 = f_tok(s, K_INT, s.line, cp);
          cnt = 2'd1;
          n.st = S_START;
          again = 1'b1;
        end else begin
          r0 = ws ? mk_err(E_EMPTY_NEG, p16(s.line), p16(cp))
                  : mk_err(E_ILL_NEG, p16(s.line), p16(s.col));
          cnt = 2'd1;
          n = f_fail(s, e, c);
        end
      end
      S_DOT1, S_DOT2: begin
        if (c == "." && s.st == S_DOT1) begin
          n = f_col(s);
          n.st = S_DOT2;
        end else if (c == ".") begin
          r0 = f_tok(s, K_DOTS, s.line, s.col);
          cnt = 2'd1;
          n = f_col(s);
          n.st = S_START;
        end else begin
          r0 = mk_err(E_UNEXPECTED, p16(s.line), p16(s.col));
          cnt = 2'd1;
          n = f_fail(s, e, c);
        end
      end
      S_COM0: begin
        if (c == "/") begin
          n = f_col(s);
          n.st = S_LINE;
        end else if (c == "*") begin
          n = f_col(s);
          n.st = S_BLOCK;
        end else begin
          r0 = mk_err(E_UNEXPECTED, p16(s.line), p16(s.col));
          cnt = 2'd1;
          n = f_fail(s, e, c);
        end
      end
      S_LINE: begin
        if (e || c == 8'h0a) begin
          n.st = S_START;
          again = 1'b1;
        end else begin
          n = f_col(s);
        end
      end
      S_BLOCK, S_STAR: begin
        if (e) begin
          r0 = mk_err(E_OPEN_COMM, p16(s.line), p16(s.col));
          cnt = 2'd1;
          n = f_fail(s, e, c);
        end else if (c == "*") begin
          n = f_col(s);
          n.st = S_STAR;
        end else if (s.st == S_STAR && c == "/") begin
          n = f_col(s);
          n.st = S_START;
        end else if (s.st == S_STAR) begin
          n.st = S_BLOCK;
          again = 1'b1;
        end else if (c == 8'h0a) begin
          n = f_nl(s);
        end else begin
          n = f_col(s);
        end
      end
      default: begin
        n.st = S_START;
        again = 1'b1;
      end
    endcase
  endfunction

  always_comb begin
    do_pass(lx, end_of_input, byte_in, n1, a0, a1, c1, g1);
    do_pass(n1, end_of_input, byte_in, n2, b0, b1, c2, g2);
    res[0] = a0;
    res[1] = a1;
    res[2] = '0;
    res_cnt = c1;
    lx_next = n1;
    if (g1) begin
      lx_next = n2;
      if (g2) lx_next.st = S_START;
      if (c1 != 2'd0) begin
        res[1] = b0;
        res[2] = b1;
        res_cnt = c2 + 2'd1;
      end else begin
        res[0] = b0;
        res[1] = b1;
        res_cnt = c2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lx.st <= S_START;
      lx.ck <= '0;
      lx.acc <= '0;
      lx.neg <= 1'b0;
      lx.ovf <= 1'b0;
      lx.line <= POne;
      lx.col <= POne;
      lx.tline <= POne;
      lx.tcol <= POne;
    end else if (fire) begin
      lx <= lx_next;
    end
  end

endmodule

@@ design/bst_outbuf.sv @@
// result register: holds up to three results of one byte and hands them out in order
// depends on bst_pkg
module bst_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  bst_pkg::result_t res [bst_pkg::MaxRes],
  input  logic [1:0]       res_cnt,
  output logic             can_load,
  output logic             m_tvalid,
  input  logic             m_tready,
  output bst_pkg::result_t m_res,
  output logic             m_last
);
  import bst_pkg::*;

  result_t    buf_q [MaxRes];
  logic [1:0] cnt;
  logic [1:0] idx;

  assign m_tvalid = cnt != 2'd0;
  assign m_res    = buf_q[idx];
  assign m_last   = (idx + 2'd1) == cnt;
  assign can_load = !m_tvalid || (m_last && m_tready);

  always_ff @(posedge clk) begin
    if (load) buf_q <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (load) begin
      cnt <= res_cnt;
      idx <= 2'd0;
    end else if (m_tvalid && m_tready) begin
      if (m_last) begin
        cnt <= 2'd0;
        idx <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

@@ design/byte_stream_tokenizer.sv @@
// top level of the byte stream tokenizer: lexer step plus result register
// depends on bst_pkg, bst_lexer, bst_outbuf
// latency: the first result of a byte is shown in the cycle after it is taken
// throughput: one byte per cycle while each byte gives at most one result and m_tready
// is high; a byte with several results (up to 3) holds the output port until all are taken
// reset: lexer in start state, line and column at 1, no results pending
module byte_stream_tokenizer #(
  parameter int POS_WIDTH   = bst_pkg::PosWidthDef,
  parameter int VALUE_WIDTH = bst_pkg::ValueWidthDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // byte_in
  input  logic                          s_tuser,   // end_of_input
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // text_byte, token_kind, error_code, int_value, overflow,
  // start_line, start_col, end_line, end_col
  output logic [bst_pkg::DataBits-1:0] m_tdata,
  output logic [1:0]                    m_tuser,   // event_res
  output logic                          m_tlast
);
  import bst_pkg::*;

  result_t    res [MaxRes];
  logic [1:0] res_cnt;
  logic       fire;
  result_t    m_res;

  assign fire = s_tvalid && s_tready;

  bst_lexer #(
    .POS_WIDTH  (POS_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_lexer (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .byte_in     (s_tdata),
    .end_of_input(s_tuser),
    .res         (res),
    .res_cnt     (res_cnt)
  );

  bst_outbuf u_outbuf (
    .clk     (clk),
    .rst     (rst),
    .load    (fire),
    .res     (res),
    .res_cnt (res_cnt),
    .can_load(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_res   (m_res),
    .m_last  (m_tlast)
  );

  assign m_tdata = DataBits'(m_res.data);
  assign m_tuser = m_res.ev;

endmodule

@@ design/bst_checker.sv @@
// port checker for the byte stream tokenizer, bound to the top level
// depends on bst_pkg and byte_stream_tokenizer
module bst_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [bst_pkg::DataBits-1:0] m_tdata,
  input logic [1:0]                    m_tuser,
  input logic                          m_tlast
);
  import bst_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with no pending result");

  a_text_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == EV_TEXT |-> m_tdata[DataBits-1:8] == '0)
    else $error("text transaction carries token fields");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == EV_TEXT || m_tuser == EV_TOKEN || m_tuser == EV_ERROR)
    else $error("bad event code");

  a_take_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && m_tvalid |-> m_tlast && m_tready)
    else $error("new byte taken over pending results");

endmodule

bind byte_stream_tokenizer bst_checker u_bst_checker (.*);

@@ test/tb.sv @@
// testbench for byte_stream_tokenizer: random and directed byte streams
// a behavioral lexer predicts each result; depends on bst_pkg and the rtl
`timescale 1ns / 1ps

module tb;
  import bst_pkg::*;

  localparam int POS_MAX = 65535;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DataBits-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;

  byte_stream_tokenizer DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct packed {
    logic [1:0] ev;
    res_data_t data;
    logic last;
  } lex_res_t;

  logic [8:0] pending_q[$];
  lex_res_t expected_q[$];
  int errors = 0;
  bit quiet = 0;
  bit hold_rx = 0;

  state_t lx_state;
  logic [3:0] cur_kind;
  logic [63:0] acc;
  bit neg, ovf;
  int line_n, col_n, tok_line, tok_col;
  lex_res_t step_res[$];

  function automatic bit is_alpha(int ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
  endfunction
  function automatic bit is_digit(int ch);
    return ch >= "0" && ch <= "9";
  endfunction
  function automatic bit is_alnum(int ch);
    return is_alpha(ch) || is_digit(ch);
  endfunction
  function automatic bit is_ident(int ch);
    return is_alnum(ch) || ch == "_" || ch == "-";
  endfunction
  function automatic bit is_ws(int ch);
    return ch == 32 || ch == 9 || ch == 13 || ch == 10;
  endfunction

  task automatic col_inc();
    if (col_n < POS_MAX) col_n++;
  endtask
  task automatic new_line();
    if (line_n < POS_MAX) line_n++;
    col_n = 1;
  endtask
  function automatic int col_prev();
    return col_n > 1 ? col_n - 1 : 1;
  endfunction

  task automatic push_text(int ch);
    lex_res_t r;
    r = '0;
    r.ev = EV_TEXT;
    r.data.text = ch[7:0];
    step_res.insert(step_res.size(), r);
  endtask

  task automatic push_tok(logic [3:0] kind, int l2, int c2);
    lex_res_t r;
    r = '0;
    r.ev = EV_TOKEN;
    r.data.kind = kind;
    if (kind == K_INT) begin
      r.data.ival = acc;
      r.data.ovf = ovf;
    end
    r.data.sl = tok_line[15:0];
    r.data.sc = tok_col[15:0];
    r.data.el = l2[15:0];
    r.data.ec = c2[15:0];
    step_res.insert(step_res.size(), r);
  endtask

  task automatic tok_here(logic [3:0] kind);
    tok_line = line_n;
    tok_col = col_n;
    push_tok(kind, line_n, col_n);
  endtask

  task automatic lex_fail(logic [3:0] code, int l, int c, int ch);
    lex_res_t r;
    r = '0;
    r.ev = EV_ERROR;
    r.data.err = code;
    r.data.sl = l[15:0];
    r.data.sc = c[15:0];
    r.data.el = l[15:0];
    r.data.ec = c[15:0];
    step_res.insert(step_res.size(), r);
    if (ch == 10) new_line();
    else if (ch >= 0) col_inc();
    lx_state = S_START;
  endtask

  task automatic mark_start();
    tok_line = line_n;
    tok_col = col_n;
    acc = '0;
    neg = 0;
    ovf = 0;
  endtask

  task automatic add_digit(int ch);
    logic [63:0] v, mag;
    v = 64'(ch - "0");
    if (!ovf) begin
      if (neg) begin
        mag = -acc;
        if (mag > ((64'h8000_0000_0000_0000 - v) / 10)) ovf = 1;
      end else if (acc > ((64'h7fff_ffff_ffff_ffff - v) / 10)) ovf = 1;
    end
    acc = neg ? acc * 10 - v : acc * 10 + v;
  endtask

  task automatic keep(int ch);
    push_text(ch);
    col_inc();
  endtask

  task automatic lex_examine(int ch, output bit again);
    again = 0;
    case (lx_state)
      S_START: begin
        if (ch < 0) tok_here(K_END);
        else if (is_alpha(ch)) begin
          mark_start(); cur_kind = K_IDENT; keep(ch);
          lx_state = (ch == "r") ? S_R : S_ID;
        end else if (ch == "-") begin
          mark_start(); col_inc(); lx_state = S_DASH;
        end else if (ch == "<") begin
          mark_start(); cur_kind = K_TYPE; col_inc(); lx_state = S_TYPE0;
        end else if (ch == 34) begin
          mark_start(); cur_kind = K_STRING; col_inc(); lx_state = S_STR;
        end else if (is_digit(ch)) begin
          mark_start(); push_text(ch); add_digit(ch); col_inc(); lx_state = S_NUM;
        end else if (ch == ".") begin
          mark_start(); col_inc(); lx_state = S_DOT1;
        end else if (ch == "/") begin
          col_inc(); lx_state = S_COM0;
        end else if (ch == "[" || ch == "]" || ch == "{" || ch == "}" || ch == ";") begin
          push_text(ch);
          tok_here(ch == "[" ? K_LSQ : ch == "]" ? K_RSQ : ch == "{" ? K_LCUR :
                   ch == "}" ? K_RCUR : K_SEMI);
          col_inc();
        end else if (ch == 10) new_line();
        else if (is_ws(ch)) col_inc();
        else lex_fail(E_UNEXPECTED, line_n, col_n, ch);
      end
      S_R, S_ID: begin
        if (lx_state == S_R && ch == 34) begin
          cur_kind = K_REGEX; col_inc(); lx_state = S_STR;
        end else if (ch >= 0 && is_ident(ch)) begin
          keep(ch); lx_state = S_ID;
        end else begin
          push_tok(K_IDENT, line_n, col_prev()); lx_state = S_START; again = 1;
        end
      end
      S_DASH: begin
        if (ch >= 0 && (is_alnum(ch) || ch == "?")) begin
          push_text(ch); push_tok(K_SHORT, line_n, col_n); col_inc(); lx_state = S_START;
        end else if (ch == "-") begin
          col_inc(); lx_state = S_DASH2;
        end else if (is_ws(ch)) lex_fail(E_EMPTY_SHORT, line_n, col_prev(), ch);
        else lex_fail(E_ILL_SHORT, line_n, col_n, ch);
      end
      S_DASH2: begin
        if (ch >= 0 && (is_alnum(ch) || ch == "_")) begin
          keep(ch); lx_state = S_LONG;
        end else if (ch == "-") begin
          keep(ch); neg = 1; lx_state = S_NUM0;
        end else if (is_ws(ch)) lex_fail(E_EMPTY_LONG, line_n, col_prev(), ch);
        else lex_fail(E_ILL_LONG, line_n, col_n, ch);
      end
      S_LONG: begin
        if (ch >= 0 && is_ident(ch)) keep(ch);
        else begin
          push_tok(K_LONG, line_n, col_prev()); lx_state = S_START; again = 1;
        end
      end
      S_TYPE0: begin
        if (ch >= 0 && is_ident(ch)) begin
          keep(ch); lx_state = S_TYPE;
        end else if (ch == ">") lex_fail(E_EMPTY_TYPE, line_n, col_n, ch);
        else lex_fail(E_ILL_TYPE, line_n, col_n, ch);
      end
      S_TYPE: begin
        if (ch >= 0 && is_ident(ch)) keep(ch);
        else if (ch == ">") begin
          push_tok(K_TYPE, line_n, col_n); col_inc(); lx_state = S_START;
        end else lex_fail(E_ILL_TYPE, line_n, col_n, ch);
      end
      S_STR: begin
        if (ch == 92) begin
          keep(ch); lx_state = S_ESC;
        end else if (ch == 34) begin
          push_tok(cur_kind == K_REGEX ? K_REGEX : K_STRING, line_n, col_n);
          col_inc(); lx_state = S_START;
        end else if (ch >= 32 && ch <= 126) keep(ch);
        else lex_fail(E_ILL_STRING, line_n, col_n, ch);
      end
      S_ESC: begin
        if (ch >= 32 && ch <= 126) begin
          keep(ch); lx_state = S_STR;
        end else lex_fail(E_ILL_STRING, line_n, col_n, ch);
      end
      S_NUM0: begin
        if (ch >= 0 && is_digit(ch)) begin
          push_text(ch); add_digit(ch); col_inc(); lx_state = S_NUM;
        end else if (is_ws(ch)) lex_fail(E_EMPTY_NEG, line_n, col_prev(), ch);
        else lex_fail(E_ILL_NEG, line_n, col_n, ch);
      end
      S_NUM: begin
        if (ch >= 0 && is_digit(ch)) begin
          push_text(ch); add_digit(ch); col_inc();
        end else if (ch == ".") begin
          keep(ch); lx_state = S_DEC;
        end else begin
          push_tok(K_INT, line_n, col_prev()); lx_state = S_START; again = 1;
        end
      end
      S_DEC: begin
        if (ch >= 0 && is_digit(ch)) keep(ch);
        else begin
          push_tok(K_DEC, line_n, col_prev()); lx_state = S_START; again = 1;
        end
      end
      S_DOT1, S_DOT2: begin
        if (ch == ".") begin
          if (lx_state == S_DOT2) begin
            push_tok(K_DOTS, line_n, col_n); lx_state = S_START;
          end else lx_state = S_DOT2;
          col_inc();
        end else lex_fail(E_UNEXPECTED, line_n, col_n, ch);
      end
      S_COM0: begin
        if (ch == "/") begin
          col_inc(); lx_state = S_LINE;
        end else if (ch == "*") begin
          col_inc(); lx_state = S_BLOCK;
        end else lex_fail(E_UNEXPECTED, line_n, col_n, ch);
      end
      S_LINE: begin
        if (ch < 0 || ch == 10) begin
          lx_state = S_START; again = 1;
        end else col_inc();
      end
      S_BLOCK: begin
        if (ch < 0) lex_fail(E_OPEN_COMM, line_n, col_n, ch);
        else if (ch == "*") begin
          col_inc(); lx_state = S_STAR;
        end else if (ch == 10) new_line();
        else col_inc();
      end
      S_STAR: begin
        if (ch < 0) lex_fail(E_OPEN_COMM, line_n, col_n, ch);
        else if (ch == "/") begin
          col_inc(); lx_state = S_START;
        end else if (ch == "*") col_inc();
        else begin
          lx_state = S_BLOCK; again = 1;
        end
      end
      default: begin
        lx_state = S_START; again = 1;
      end
    endcase
  endtask

  task automatic lex_step(logic [7:0] b, logic eoi);
    int ch;
    bit again;
    lex_res_t r;
    ch = eoi ? -1 : int'(b);
    step_res.delete();
    for (int p = 0; p < 3; p++) begin
      lex_examine(ch, again);
      if (!again) break;
    end
    for (int i = 0; i < step_res.size(); i++) begin
      r = step_res[i];
      r.last = (i == step_res.size() - 1);
      expected_q.insert(expected_q.size(), r);
    end
  endtask

  // driver
  int tx_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        s_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        tx_gap <= $urandom_range(1, 18);
        s_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        s_tvalid <= 1'b1;
        {s_tuser, s_tdata} <= pending_q[0];
      end else s_tvalid <= 1'b0;
    end
  end

  // receiver back-pressure
  int rx_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_rx) m_tready <= 1'b0;
      else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rx_gap <= $urandom_range(1, 18);
        m_tready <= 1'b0;
      end else m_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    lex_res_t got, exp_r;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        lex_step(s_tdata, s_tuser);
        void'(pending_q.pop_front());
      end
      if (m_tvalid && m_tready) begin
        got.ev = m_tuser;
        got.data = m_tdata[$bits(res_data_t)-1:0];
        got.last = m_tlast;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%t unexpected result: actual %h", $realtime, got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got != exp_r) begin
            errors++;
            $display("%t mismatch: expected ev %0d text %h kind %0d err %0d val %h ovf %b",
                     $realtime, exp_r.ev, exp_r.data.text, exp_r.data.kind, exp_r.data.err,
                     exp_r.data.ival, exp_r.data.ovf);
            $display("    pos %0d:%0d-%0d:%0d last %b", exp_r.data.sl, exp_r.data.sc,
                     exp_r.data.el, exp_r.data.ec, exp_r.last);
            $display("  actual ev %0d text %h kind %0d err %0d val %h ovf %b", got.ev,
                     got.data.text, got.data.kind, got.data.err, got.data.ival, got.data.ovf);
            $display("    pos %0d:%0d-%0d:%0d last %b", got.data.sl, got.data.sc,
                     got.data.el, got.data.ec, got.last);
          end
        end
      end
    end
  end

  task automatic put_byte(logic eoi, logic [7:0] b);
    pending_q.insert(pending_q.size(), {eoi, b});
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put_byte(1'b0, s[i]);
  endtask

  task automatic put_rand_token();
    int k, n;
    string alnum;
    alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-";
    k = $urandom_range(0, 13);
    n = $urandom_range(1, 5);
    case (k)
      0: begin
        put_str("a");
        repeat (n) put_byte(1'b0, alnum[$urandom_range(0, 63)]);
      end
      1: begin
        put_str("r\"");
        repeat (n) put_byte(1'b0, 8'($urandom_range(32, 126)));
        put_str("\"");
      end
      2: begin
        put_str("\"");
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) put_str("\\");
          put_byte(1'b0, 8'($urandom_range(32, 126)));
        end
        put_str("\"");
      end
      3: begin
        put_str("-");
        put_byte(1'b0, alnum[$urandom_range(0, 61)]);
      end
      4: begin
        put_str("--x");
        repeat (n) put_byte(1'b0, alnum[$urandom_range(0, 63)]);
      end
      5: begin
        if ($urandom_range(0, 1)) put_str("---");
        repeat ($urandom_range(1, 22)) put_byte(1'b0, 8'($urandom_range(48, 57)));
        if ($urandom_range(0, 2) == 0) put_str(".5");
      end
      6: begin
        put_str("<T");
        repeat (n) put_byte(1'b0, alnum[$urandom_range(0, 63)]);
        put_str(">");
      end
      7: put_str("...");
      8: put_str($urandom_range(0, 1) ? "// note\n" : "/* a*b **/");
      9: put_byte(1'b0, 8'("[]{};" >> (8 * $urandom_range(0, 4))));
      10: put_str($urandom_range(0, 1) ? "\n" : " \t\r");
      11: put_byte(1'b0, 8'($urandom_range(0, 255)));
      12: put_byte(1'b1, 8'($urandom_range(0, 255)));
      default: put_str(" ");
    endcase
    put_str(" ");
  endtask

  initial begin
    int hold;
    lx_state = S_START;
    cur_kind = '0;
    acc = '0;
    neg = 0;
    ovf = 0;
    line_n = 1;
    col_n = 1;
    tok_line = 1;
    tok_col = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    put_str("abc r\"x\\\"y\" -q --long ---42 9223372036854775808 1.25 ... ");
    put_str("<Ty> [ ] { } ; // c\n/* x */ -  --  --- <> < \"\001 .x /x ");
    put_str("-! --! ---x ");
    put_byte(1'b0, 8'hff);
    put_str(" r");
    put_byte(1'b1, 8'h00);
    put_str("/* never");
    put_byte(1'b1, 8'hff);
    put_byte(1'b1, 8'h00);
    for (int i = 0; i < 4; i++) put_rand_token();
    hold = 0;
    while (pending_q.size() > 0) begin
      @(negedge clk);
      if (hold == 0 && pending_q.size() < 150) begin
        hold_rx = 1;
        repeat (60) @(negedge clk);
        hold_rx = 0;
        hold = 1;
      end
      if (pending_q.size() < 40) quiet = 1;
    end
    quiet = 1;
    put_str("12");
    for (int i = 0; i < 4; i++) put_rand_token();
    wait (pending_q.size() == 0);
    wait (expected_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
design/bst_pkg.sv
design/bst_lexer.sv
design/bst_outbuf.sv
design/byte_stream_tokenizer.sv
design/bst_checker.sv
test/tb.sv
